// ===== rtl/greedy_clique_with_dedup_macros.svh =====
// Assertion macros for the greedy clique block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef GREEDY_CLIQUE_WITH_DEDUP_MACROS_SVH
`define GREEDY_CLIQUE_WITH_DEDUP_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define GCWD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gcwd_pkg.sv =====
// Shared types and constants for the greedy clique block.
// No dependencies.
package gcwd_pkg;

  localparam int Nodes       = 64;
  localparam int MaxCliques  = 64;
  localparam int NodeW       = 6;
  localparam int SlotW       = 6;
  localparam int CountW      = $clog2(MaxCliques + 1);

  typedef logic [Nodes-1:0] mask_t;

  localparam mask_t NodeMask = '1;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActOffer = 1'b1;

  typedef struct packed {
    logic             action;
    logic [NodeW-1:0] node;
    logic [63:0]      row_bits;
    logic             last_in_order;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0] member;
    logic [SlotW-1:0] set_slot;
    logic             newly_stored;
    logic             set_full;
    logic             last_member;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic load_row;
    logic offer;
    logic scan_first;
    logic scan_next;
    logic resolve_found;
    logic resolve_insert;
    logic resolve_full;
    logic emit_start;
    logic emit_step;
    logic clear_clique;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
    logic nonempty;
    logic scan_end;
    logic match;
    logic room;
    logic rem_empty;
    logic out_ready;
  } dp_status_t;

endpackage

// ===== rtl/gcwd_dp.sv =====
// Datapath: conflict row memory, clique masks, clique store scan,
// ascending member walk and output register. Uses gcwd_pkg.
module gcwd_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gcwd_pkg::in_item_t    in_item_i,
  input  gcwd_pkg::dp_cmd_t     cmd_i,
  output gcwd_pkg::dp_status_t  status_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output gcwd_pkg::out_item_t   out_item_o
);

  gcwd_pkg::mask_t conflict_mem [gcwd_pkg::Nodes];
  gcwd_pkg::mask_t clique_mem [gcwd_pkg::MaxCliques];

  gcwd_pkg::mask_t own_row_q;
  gcwd_pkg::mask_t clique_rd_q;
  gcwd_pkg::mask_t member_q, common_q;
  gcwd_pkg::mask_t member_new, common_new, node_bit;
  gcwd_pkg::mask_t rem_q;
  logic [gcwd_pkg::NodeW-1:0]  node_q, idx_q;
  logic                        last_q, join_ok;
  logic [gcwd_pkg::CountW-1:0] scan_q, scan_d, count_q;
  logic [gcwd_pkg::SlotW-1:0]  slot_q;
  logic                        fresh_q, full_q;
  logic                        out_valid_q, out_ready;
  gcwd_pkg::out_item_t         out_item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) begin
      conflict_mem[in_item_i.node] <= in_item_i.row_bits & gcwd_pkg::NodeMask;
    end
    if (cmd_i.capture) begin
      own_row_q <= conflict_mem[in_item_i.node];
      node_q    <= in_item_i.node;
      last_q    <= in_item_i.last_in_order;
    end
  end

  // Join test: candidate in every member's row and every member in its row
  always_comb begin
    node_bit   = gcwd_pkg::mask_t'(1) << node_q;
    join_ok    = common_q[node_q] && ((own_row_q & member_q) == member_q);
    member_new = join_ok ? (member_q | node_bit) : member_q;
    common_new = join_ok ? (common_q & own_row_q) : common_q;
  end

  always_comb begin
    priority if (cmd_i.scan_first) begin
      scan_d = '0;
    end else if (cmd_i.scan_next) begin
      scan_d = scan_q + gcwd_pkg::CountW'(1);
    end else begin
      scan_d = scan_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve_insert) begin
      clique_mem[count_q[gcwd_pkg::SlotW-1:0]] <= member_q;
    end
    clique_rd_q <= clique_mem[scan_d[gcwd_pkg::SlotW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_q    <= '0;
      common_q    <= '1;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_clique) begin
        member_q <= '0;
        common_q <= '1;
      end else if (cmd_i.offer) begin
        member_q <= member_new;
        common_q <= common_new;
      end
      if (cmd_i.resolve_insert) begin
        count_q <= count_q + gcwd_pkg::CountW'(1);
      end
      if (cmd_i.emit_step && rem_q[0]) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    if (cmd_i.resolve_found) begin
      slot_q  <= scan_q[gcwd_pkg::SlotW-1:0];
      fresh_q <= 1'b0;
      full_q  <= 1'b0;
    end else if (cmd_i.resolve_insert) begin
      slot_q  <= count_q[gcwd_pkg::SlotW-1:0];
      fresh_q <= 1'b1;
      full_q  <= 1'b0;
    end else if (cmd_i.resolve_full) begin
      slot_q  <= '0;
      fresh_q <= 1'b0;
      full_q  <= 1'b1;
    end
    // Walk members low to high by shifting the mask down
    if (cmd_i.emit_start) begin
      rem_q <= member_q;
      idx_q <= '0;
    end else if (cmd_i.emit_step) begin
      rem_q <= rem_q >> 1;
      idx_q <= idx_q + gcwd_pkg::NodeW'(1);
    end
    if (cmd_i.emit_step && rem_q[0]) begin
      out_item_q.member       <= idx_q;
      out_item_q.set_slot     <= slot_q;
      out_item_q.newly_stored <= fresh_q;
      out_item_q.set_full     <= full_q;
      out_item_q.last_member  <= (rem_q[gcwd_pkg::Nodes-1:1] == '0);
    end
  end

  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    status_o.last      = last_q;
    status_o.nonempty  = (member_new != '0);
    status_o.scan_end  = (scan_q == count_q);
    status_o.match     = (clique_rd_q == member_q);
    status_o.room      = (count_q < gcwd_pkg::CountW'(gcwd_pkg::MaxCliques));
    status_o.rem_empty = (rem_q == '0);
    status_o.out_ready = out_ready;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/gcwd_ctrl.sv =====
// Controller state machine for the greedy clique block.
// Drives datapath commands from status; uses gcwd_pkg.
module gcwd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_action_i,
  output logic                  in_stall_o,
  input  gcwd_pkg::dp_status_t  status_i,
  output gcwd_pkg::dp_cmd_t     cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StOffer  = 2'd1;
  localparam logic [1:0] StSearch = 2'd2;
  localparam logic [1:0] StEmit   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture  = 1'b1;
          cmd_o.load_row = (in_action_i == gcwd_pkg::ActLoad);
          if (in_action_i == gcwd_pkg::ActOffer) begin
            state_d = StOffer;
          end
        end
      end
      StOffer: begin
        cmd_o.offer = 1'b1;
        state_d     = StIdle;
        if (status_i.last) begin
          if (status_i.nonempty) begin
            cmd_o.scan_first = 1'b1;
            state_d          = StSearch;
          end else begin
            cmd_o.clear_clique = 1'b1;
          end
        end
      end
      StSearch: begin
        priority if (status_i.scan_end) begin
          cmd_o.resolve_insert = status_i.room;
          cmd_o.resolve_full   = !status_i.room;
          cmd_o.emit_start     = 1'b1;
          state_d              = StEmit;
        end else if (status_i.match) begin
          cmd_o.resolve_found = 1'b1;
          cmd_o.emit_start    = 1'b1;
          state_d             = StEmit;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      StEmit: begin
        if (status_i.rem_empty) begin
          cmd_o.clear_clique = 1'b1;
          state_d            = StIdle;
        end else if (status_i.out_ready) begin
          cmd_o.emit_step = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

// ===== rtl/greedy_clique_with_dedup.sv =====
// Top level of the greedy clique builder with clique store.
// Joins gcwd_ctrl and gcwd_dp; uses gcwd_pkg and the assertion macros.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): a load item
// (action 0) writes one node's conflict row without stalling the input. An
// offer item (action 1) reads the node's row from the row memory into a
// register and updates the clique in the next cycle.
// On an offer marked last with a non-empty clique, the block scans the
// stored cliques one entry a cycle, then inserts the clique if new and
// room remains, and walks the mask bits from low to high, one bit a cycle
// while the output is not stalled, up to the highest member, placing each
// member in the output register.
// Output channel (out_valid_o / out_stall_i / out_item_o): one item per
// member, ascending, last_member on the highest. A stall holds the output
// register and pauses the walk; the input stalls until the walk is done.
// Reset clears the clique, the stored count and the output valid flag;
// row and store memories are not cleared, and the scan compares only
// written store entries.
`include "greedy_clique_with_dedup_macros.svh"

module greedy_clique_with_dedup (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gcwd_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gcwd_pkg::out_item_t  out_item_o
);

  gcwd_pkg::dp_cmd_t    cmd;
  gcwd_pkg::dp_status_t status;
  logic                 offer_taken;
  logic [2:0]           resolve_vec;
  logic                 flags_clash;

  gcwd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_item_i.action),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gcwd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  assign offer_taken = in_valid_i && !in_stall_o &&
                       (in_item_i.action == gcwd_pkg::ActOffer);
  assign resolve_vec = {cmd.resolve_found, cmd.resolve_insert, cmd.resolve_full};
  assign flags_clash = out_valid_o && out_item_o.newly_stored && out_item_o.set_full;

  `GCWD_ASSERT_NEXT(a_offer_blocks_input, offer_taken, in_stall_o, "input taken mid offer")
  `GCWD_ASSERT_ALWAYS(a_one_resolve, $onehot0(resolve_vec), "two store outcomes at once")
  `GCWD_ASSERT_ALWAYS(a_flags_exclusive, !flags_clash, "item both stored and flagged full")
  `GCWD_ASSERT_ALWAYS(a_emit_only_busy, !(cmd.emit_step && !in_stall_o), "walk with input open")

endmodule

// ===== dv/tb_greedy_clique_with_dedup.sv =====
// Testbench for greedy_clique_with_dedup: directed and random load/offer items,
// checked member by member against a clique predictor kept in this file.
// Depends on gcwd_pkg and the greedy_clique_with_dedup RTL.
module tb_greedy_clique_with_dedup;
  import gcwd_pkg::*;

  localparam int RandomItems  = 410;
  localparam int LongHold     = 400;
  localparam int SettleCycles = 150;
  localparam int CycleLimit   = 3_000_000;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          drain;
  } send_t;

  logic      clk_i    = 1'b0;
  logic      rst_ni   = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  send_t     send_q[$];
  out_item_t member_q[$];

  // predicted block state
  mask_t       conflict_row [Nodes];
  mask_t       clique_mask = '0;
  mask_t       common_mask = '1;
  mask_t       clique_store [MaxCliques];
  int unsigned store_count = 0;

  bit          row_loaded [Nodes];
  bit          drain_next = 1'b0;
  int unsigned gen_count = 0;
  int          errors = 0;
  int          results_seen = 0;
  int unsigned cycles = 0;
  int unsigned gap_left = 0;
  bit          gap_armed = 1'b0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;
  bit          long_hold_done = 1'b0;

  greedy_clique_with_dedup uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  task automatic report_mismatch(input string msg);
    if (errors < 50) $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // Apply one accepted item to the clique state; queue the members it emits.
  task automatic update_clique(input in_item_t it);
    mask_t     node_bit;
    mask_t     own;
    int        slot;
    bit        fresh;
    bit        full;
    bit        found;
    out_item_t r;
    if (it.action == ActLoad) begin
      conflict_row[it.node] = it.row_bits & NodeMask;
      return;
    end
    node_bit = mask_t'(1) << it.node;
    own = conflict_row[it.node];
    if ((common_mask & node_bit) != '0 && (own & clique_mask) == clique_mask) begin
      clique_mask |= node_bit;
      common_mask &= own;
    end
    if (!it.last_in_order) return;
    if (clique_mask != '0) begin
      found = 1'b0;
      fresh = 1'b0;
      full = 1'b0;
      slot = 0;
      for (int i = 0; i < store_count; i++) begin
        if (!found && clique_store[i] == clique_mask) begin
          found = 1'b1;
          slot = i;
        end
      end
      if (!found) begin
        if (store_count < MaxCliques) begin
          slot = store_count;
          clique_store[store_count] = clique_mask;
          store_count++;
          fresh = 1'b1;
        end else begin
          full = 1'b1;
        end
      end
      for (int i = 0; i < Nodes; i++) begin
        if (clique_mask[i]) begin
          r.member = NodeW'(i);
          r.set_slot = SlotW'(slot);
          r.newly_stored = fresh;
          r.set_full = full;
          r.last_member = ((clique_mask >> i) >> 1) == '0;
          member_q.push_back(r);
        end
      end
    end
    clique_mask = '0;
    common_mask = '1;
  endtask

  // Mostly back to back or short gaps, a few long ones, and stretches with no gaps.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if ((gen_count / 40) % 4 == 3) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [63:0] rand_row();
    logic [63:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return '1;
      1: return '0;
      2, 3, 4: return ~(a & {$urandom, $urandom} & {$urandom, $urandom});
      default: return a;
    endcase
  endfunction

  function automatic int pick_loaded();
    int n;
    do n = $urandom_range(63); while (!row_loaded[n]);
    return n;
  endfunction

  task automatic push_item(input logic act, input int node, input logic [63:0] row,
                           input logic last);
    send_t s;
    s.item.action = act;
    s.item.node = NodeW'(node);
    s.item.row_bits = row;
    s.item.last_in_order = last;
    s.gap = pick_gap();
    s.drain = drain_next;
    drain_next = 1'b0;
    if (act == ActLoad) row_loaded[node] = 1'b1;
    send_q.push_back(s);
    gen_count++;
  endtask

  // Driver: present queued items, honoring gaps and drain points.
  always @(posedge clk_i) begin
    logic nv;
    if (rst_ni) begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        update_clique(in_item);
        void'(send_q.pop_front());
        nv = 1'b0;
        gap_armed = 1'b0;
      end
      if (!nv && send_q.size() > 0) begin
        if (!gap_armed) begin
          gap_left = send_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!send_q[0].drain || member_q.size() == 0) begin
          nv = 1'b1;
          in_item <= send_q[0].item;
        end
      end
      in_valid <= nv;
    end
  end

  // Receiver stall: random bursts, quiet stretches, and one long hold.
  always @(posedge clk_i) begin
    logic        ns;
    int unsigned r;
    if (rst_ni) begin
      ns = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        ns = 1'b1;
      end else if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        hold_left = LongHold - 1;
        ns = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        ns = 1'b1;
      end else if ((cycles / 500) % 3 != 2) begin
        r = $urandom_range(99);
        if (r < 10) begin
          burst_left = $urandom_range(2);
          ns = 1'b1;
        end else if (r < 12) begin
          burst_left = $urandom_range(40, 15);
          ns = 1'b1;
        end
      end
      out_stall <= ns;
    end
  end

  // Monitor: compare each accepted member with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (member_q.size() == 0) begin
        report_mismatch($sformatf("unexpected member %0d", out_item.member));
      end else begin
        want = member_q.pop_front();
        if (out_item.member !== want.member)
          report_mismatch($sformatf("member %0d, want %0d", out_item.member, want.member));
        if (out_item.set_slot !== want.set_slot)
          report_mismatch($sformatf("set_slot %0d, want %0d (member %0d)",
                                    out_item.set_slot, want.set_slot, want.member));
        if (out_item.newly_stored !== want.newly_stored)
          report_mismatch($sformatf("newly_stored %b, want %b (member %0d)",
                                    out_item.newly_stored, want.newly_stored, want.member));
        if (out_item.set_full !== want.set_full)
          report_mismatch($sformatf("set_full %b, want %b (member %0d)",
                                    out_item.set_full, want.set_full, want.member));
        if (out_item.last_member !== want.last_member)
          report_mismatch($sformatf("last_member %b, want %b (member %0d)",
                                    out_item.last_member, want.last_member, want.member));
      end
    end
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned len;
    int unsigned stop_at;
    bit          mid_drain;
    mid_drain = 1'b0;

    // directed: extreme nodes and rows, first offer, repeat offer, rejection,
    // duplicate clique, rewritten row, load carrying a last mark
    push_item(ActLoad, 0, '1, 1'b0);
    push_item(ActLoad, 63, '1, 1'b0);
    push_item(ActLoad, 1, '0, 1'b0);
    push_item(ActLoad, 2, 64'h8000_0000_0000_0001, 1'b0);
    push_item(ActOffer, 0, {$urandom, $urandom}, 1'b0);
    push_item(ActOffer, 0, {$urandom, $urandom}, 1'b0);
    push_item(ActOffer, 63, {$urandom, $urandom}, 1'b0);
    push_item(ActOffer, 2, {$urandom, $urandom}, 1'b0);
    push_item(ActOffer, 1, '1, 1'b1);
    push_item(ActOffer, 1, '0, 1'b1);
    push_item(ActOffer, 0, {$urandom, $urandom}, 1'b0);
    push_item(ActOffer, 63, {$urandom, $urandom}, 1'b0);
    push_item(ActOffer, 2, {$urandom, $urandom}, 1'b1);
    push_item(ActOffer, 2, {$urandom, $urandom}, 1'b0);
    push_item(ActOffer, 1, {$urandom, $urandom}, 1'b1);
    push_item(ActLoad, 1, '1, 1'b0);
    push_item(ActLoad, 62, '1, 1'b1);
    push_item(ActOffer, 0, {$urandom, $urandom}, 1'b0);
    push_item(ActOffer, 1, {$urandom, $urandom}, 1'b1);
    push_item(ActOffer, 63, {$urandom, $urandom}, 1'b1);

    // pause the sender until the directed members are all out
    drain_next = 1'b1;
    stop_at = gen_count + RandomItems;
    for (int n = 0; n < Nodes; n++) push_item(ActLoad, n, rand_row(), 1'($urandom_range(1)));
    while (gen_count < stop_at) begin
      r = $urandom_range(99);
      if (r < 12) begin
        push_item(ActLoad, $urandom_range(63), rand_row(), 1'($urandom_range(1)));
      end else if (r < 30) begin
        // single low node: repeats hit cliques already stored
        push_item(ActOffer, $urandom_range(3), {$urandom, $urandom}, 1'b1);
      end else begin
        r = $urandom_range(99);
        if (r < 40) len = 1;
        else if (r < 75) len = 2;
        else if (r < 92) len = $urandom_range(5, 3);
        else len = $urandom_range(16, 6);
        for (int k = 0; k < len; k++)
          push_item(ActOffer, pick_loaded(), {$urandom, $urandom}, k == len - 1);
      end
      if (!mid_drain && gen_count > 250) begin
        drain_next = 1'b1;
        mid_drain = 1'b1;
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (send_q.size() == 0);
    wait (member_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
